@@ design/i2c_bus_clear_sequencer_macros.svh @@
// Assertion helpers shared by the bus-clear design files.
// Both expect signals named clk and arst_n in the calling module.
`ifndef I2C_BUS_CLEAR_SEQUENCER_MACROS_SVH
`define I2C_BUS_CLEAR_SEQUENCER_MACROS_SVH

// Consequent checked on the same edge as the antecedent.
`define I2CBC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked on the edge following the antecedent.
`define I2CBC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/i2cbc_pkg.sv @@
package i2cbc_pkg;

	localparam logic [7:0] HALF_PERIOD_RESET = 8'd5;
	localparam logic [4:0] PULSE_COUNT_RESET = 5'd20;

	// register index, from paddr[2]
	typedef enum logic {
		REG_HALF_PERIOD = 1'b0,
		REG_PULSE_COUNT = 1'b1
	} reg_idx_t;

	typedef enum logic [11:0] {
		PH_IDLE     = 12'b0000_0000_0001,
		PH_A_LOW    = 12'b0000_0000_0010,
		PH_A_HIGH   = 12'b0000_0000_0100,
		PH_B_LOW    = 12'b0000_0000_1000,
		PH_B_HIGH   = 12'b0000_0001_0000,
		PH_B_SAMPLE = 12'b0000_0010_0000,
		PH_C_LOW    = 12'b0000_0100_0000,
		PH_C_HIGH   = 12'b0000_1000_0000,
		PH_CLK_LOW  = 12'b0001_0000_0000,
		PH_CLK_HIGH = 12'b0010_0000_0000,
		PH_D_LOW    = 12'b0100_0000_0000,
		PH_D_HIGH   = 12'b1000_0000_0000
	} phase_t;

	typedef struct packed {
		logic start_request;
		logic scl_sample;
		logic sda_sample;
	} in_item_t;

	typedef struct packed {
		logic scl_drive_enable;
		logic scl_drive_level;
		logic sda_drive_enable;
		logic sda_drive_level;
		logic busy_res;
		logic done_pulse;
	} out_item_t;

	typedef struct packed {
		logic [7:0] half_period_ticks;
		logic [4:0] clock_pulse_count;
	} cfg_t;

endpackage

@@ design/i2c_bus_clear_sequencer.sv @@
// Channel   Direction  Handshake            Beat payload
// in        input      in_valid/in_ready    in_item  (start_request, scl_sample, sda_sample)
// out       output     out_valid/out_ready  out_item (SCL/SDA drive, busy_res, done_pulse)
// apb       cfg        psel/penable/pready  half_period_ticks @0x0, clock_pulse_count @0x4
//
// One beat in, one beat out; each beat passes the input register, then the result register.
// Throughput is one beat per cycle while out does not stall: the step logic is a
// single pass through the phase machine between the input and result registers.
// Reset (arst_n low) empties both registers and returns the sequencer to idle
// with both pins released; registers return to 5 ticks and 20 pulses.
// A stall on out holds the result register and the pending input beat; in_ready
// stays high while the input register can move on or is empty.
module i2c_bus_clear_sequencer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  i2cbc_pkg::in_item_t  in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output i2cbc_pkg::out_item_t out_item,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import i2cbc_pkg::*;

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res;
	out_item_t res_s2;
	logic      valid_s2;
	logic      adv;

	// the input beat steps the machine when the result register is free or draining
	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	i2cbc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	i2cbc_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.item_s1 (item_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = res_s2;

`include "i2c_bus_clear_sequencer_macros.svh"

	`I2CBC_ASSERT_NEXT(a_adv_fills_out, adv, valid_s2, "stepped beat lost")
	`I2CBC_ASSERT_NOW(a_adv_needs_room, adv, valid_s1 && (!valid_s2 || out_ready), "step with no room")
	`I2CBC_ASSERT_NEXT(a_stall_holds_s1, valid_s1 && !adv, valid_s1 && $stable(item_s1), "pending beat dropped")

endmodule

@@ design/i2cbc_regs.sv @@
module i2cbc_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	output i2cbc_pkg::cfg_t cfg
);
	import i2cbc_pkg::*;

	logic [7:0] half_period_q;
	logic [4:0] pulse_count_q;
	logic       wr_en;
	reg_idx_t   idx;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[2]);
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RESET;
			pulse_count_q <= PULSE_COUNT_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_HALF_PERIOD: half_period_q <= pwdata[7:0];
				REG_PULSE_COUNT: pulse_count_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_HALF_PERIOD: prdata = {24'd0, half_period_q};
			REG_PULSE_COUNT: prdata = {27'd0, pulse_count_q};
			default:         prdata = 32'd0;
		endcase
	end

	assign cfg.half_period_ticks = half_period_q;
	assign cfg.clock_pulse_count = pulse_count_q;

endmodule

@@ design/i2cbc_step.sv @@
module i2cbc_step (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  i2cbc_pkg::in_item_t  item_s1,
	input  i2cbc_pkg::cfg_t      cfg,
	output i2cbc_pkg::out_item_t res
);
	import i2cbc_pkg::*;

	phase_t     phase_q, phase_d;
	logic [7:0] tick_q, tick_d;
	logic [4:0] pulse_q, pulse_d;
	logic       scl_en_q, scl_en_d, sda_en_q, sda_en_d;
	logic       scl_lvl_q, scl_lvl_d, sda_lvl_q, sda_lvl_d;
	logic       done;

	logic [7:0] hold;
	logic [8:0] tick_inc;
	logic       elapsed;
	logic [4:0] pulse_inc;
	logic       both_high;
	logic       do_clk, do_final;

	assign hold      = (cfg.half_period_ticks == 8'd0) ? 8'd1 : cfg.half_period_ticks;
	assign tick_inc  = {1'b0, tick_q} + 9'd1;
	assign elapsed   = tick_inc >= {1'b0, hold};
	assign pulse_inc = pulse_q + 5'd1;
	assign both_high = item_s1.scl_sample & item_s1.sda_sample;

	always_comb begin
		phase_d   = phase_q;
		tick_d    = tick_q;
		pulse_d   = pulse_q;
		scl_en_d  = scl_en_q;
		sda_en_d  = sda_en_q;
		scl_lvl_d = scl_lvl_q;
		sda_lvl_d = sda_lvl_q;
		done      = 1'b0;
		do_clk    = 1'b0;
		do_final  = 1'b0;

		// hold counter: advances in every timed phase
		if (phase_q != PH_IDLE && phase_q != PH_B_SAMPLE)
			tick_d = elapsed ? 8'd0 : tick_inc[7:0];

		case (phase_q)
			PH_IDLE: begin
				if (item_s1.start_request) begin
					tick_d   = 8'd0;
					scl_en_d = 1'b1;
					if (both_high) begin
						scl_lvl_d = 1'b1;
						sda_en_d  = 1'b1;
						sda_lvl_d = 1'b0;
						phase_d   = PH_A_LOW;
					end else begin
						scl_lvl_d = 1'b0;
						phase_d   = PH_B_LOW;
					end
				end
			end
			PH_A_LOW: if (elapsed) begin
				sda_lvl_d = 1'b1;
				phase_d   = PH_A_HIGH;
			end
			PH_C_LOW: if (elapsed) begin
				sda_lvl_d = 1'b1;
				phase_d   = PH_C_HIGH;
			end
			PH_D_LOW: if (elapsed) begin
				sda_lvl_d = 1'b1;
				phase_d   = PH_D_HIGH;
			end
			PH_A_HIGH, PH_C_HIGH: do_clk = elapsed;
			PH_B_LOW: if (elapsed) begin
				scl_lvl_d = 1'b1;
				phase_d   = PH_B_HIGH;
			end
			PH_B_HIGH: if (elapsed) begin
				scl_en_d  = 1'b0;
				scl_lvl_d = 1'b1;
				phase_d   = PH_B_SAMPLE;
			end
			PH_B_SAMPLE: begin
				tick_d = 8'd0;
				if (both_high) begin
					sda_en_d  = 1'b1;
					sda_lvl_d = 1'b0;
					phase_d   = PH_C_LOW;
				end else begin
					do_clk = 1'b1;
				end
			end
			PH_CLK_LOW: if (elapsed) begin
				scl_lvl_d = 1'b1;
				phase_d   = PH_CLK_HIGH;
			end
			PH_CLK_HIGH: if (elapsed) begin
				pulse_d = pulse_inc;
				if (pulse_inc >= cfg.clock_pulse_count) begin
					do_final = 1'b1;
				end else begin
					scl_lvl_d = 1'b0;
					phase_d   = PH_CLK_LOW;
				end
			end
			PH_D_HIGH: if (elapsed) begin
				scl_en_d  = 1'b0;
				sda_en_d  = 1'b0;
				scl_lvl_d = 1'b1;
				sda_lvl_d = 1'b1;
				phase_d   = PH_IDLE;
				done      = 1'b1;
			end
			default: begin
				scl_en_d  = 1'b0;
				sda_en_d  = 1'b0;
				scl_lvl_d = 1'b1;
				sda_lvl_d = 1'b1;
				phase_d   = PH_IDLE;
				tick_d    = 8'd0;
			end
		endcase

		// enter the clocking phase; a zero pulse count goes straight to the final check
		if (do_clk) begin
			scl_en_d = 1'b1;
			tick_d   = 8'd0;
			pulse_d  = 5'd0;
			if (cfg.clock_pulse_count == 5'd0) begin
				scl_lvl_d = 1'b1;
				do_final  = 1'b1;
			end else begin
				scl_lvl_d = 1'b0;
				phase_d   = PH_CLK_LOW;
			end
		end

		if (do_final) begin
			tick_d = 8'd0;
			if (both_high) begin
				sda_en_d  = 1'b1;
				sda_lvl_d = 1'b0;
				phase_d   = PH_D_LOW;
			end else begin
				scl_en_d  = 1'b0;
				sda_en_d  = 1'b0;
				scl_lvl_d = 1'b1;
				sda_lvl_d = 1'b1;
				phase_d   = PH_IDLE;
				done      = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			tick_q    <= 8'd0;
			pulse_q   <= 5'd0;
			scl_en_q  <= 1'b0;
			sda_en_q  <= 1'b0;
			scl_lvl_q <= 1'b1;
			sda_lvl_q <= 1'b1;
		end else if (adv) begin
			phase_q   <= phase_d;
			tick_q    <= tick_d;
			pulse_q   <= pulse_d;
			scl_en_q  <= scl_en_d;
			sda_en_q  <= sda_en_d;
			scl_lvl_q <= scl_lvl_d;
			sda_lvl_q <= sda_lvl_d;
		end
	end

	assign res.scl_drive_enable = scl_en_d;
	assign res.scl_drive_level  = scl_lvl_d;
	assign res.sda_drive_enable = sda_en_d;
	assign res.sda_drive_level  = sda_lvl_d;
	assign res.busy_res         = phase_d != PH_IDLE;
	assign res.done_pulse       = done;

`include "i2c_bus_clear_sequencer_macros.svh"

	`I2CBC_ASSERT_NOW(a_idle_released, phase_q == PH_IDLE, !scl_en_q && !sda_en_q, "pins driven while idle")
	`I2CBC_ASSERT_NOW(a_scl_rel_high, !scl_en_q, scl_lvl_q, "released SCL level not high")
	`I2CBC_ASSERT_NOW(a_done_to_idle, adv && done, phase_d == PH_IDLE && !scl_en_d && !sda_en_d, "done without release")
	`I2CBC_ASSERT_NEXT(a_hold_state, !adv, $stable(phase_q) && $stable(tick_q), "state moved without a beat")

endmodule

@@ dv/i2c_bus_clear_sequencer_test.sv @@
`timescale 1ns / 100ps

module i2c_bus_clear_sequencer_test;
	import i2cbc_pkg::*;

	// how the sampled SCL/SDA levels evolve over one recovery run
	typedef enum {
		LINES_HIGH,
		LINES_LOW,
		LINES_RELEASE,	// stuck on the start tick, free afterwards
		LINES_RANDOM
	} line_mode_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	in_item_t   in_item = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_item_t  out_item;
	logic       psel = 1'b0;
	logic       penable = 1'b0;
	logic       pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic       pready;

	i2c_bus_clear_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// ---------------------------------------------------------------
	// Sequencer mirror: register copies plus the phase machine state.
	// ---------------------------------------------------------------
	logic [7:0] hold_cfg;
	logic [4:0] pulses_cfg;
	phase_t     seq_phase;
	logic [7:0] hold_cnt;
	logic [4:0] pulse_cnt;
	logic       scl_en, scl_lvl, sda_en, sda_lvl;

	out_item_t  pins_expected[$];	// one predicted pin beat per accepted tick
	out_item_t  pins_want;
	int         mismatches = 0;
	int         ticks_sent = 0;
	bit         no_stall = 1'b0;	// suppress idling on both sides

	// True once the current level has been held long enough; a hold of 0
	// behaves as 1. The tick that set the level counts as the first.
	function automatic bit hold_over();
		int limit;
		limit = (hold_cfg == 8'd0) ? 1 : int'(hold_cfg);
		if (int'(hold_cnt) + 1 >= limit) begin
			hold_cnt = '0;
			return 1'b1;
		end
		hold_cnt = hold_cnt + 8'd1;
		return 1'b0;
	endfunction

	// released pins read back as level 1
	function automatic void release_pins();
		scl_en  = 1'b0;
		sda_en  = 1'b0;
		scl_lvl = 1'b1;
		sda_lvl = 1'b1;
	endfunction

	// after clocking: final pseudo-stop if the bus is free, else finish
	function automatic bit final_stop_or_end(logic both_high);
		hold_cnt = '0;
		if (both_high) begin
			sda_en    = 1'b1;
			sda_lvl   = 1'b0;
			seq_phase = PH_D_LOW;
			return 1'b0;
		end
		release_pins();
		seq_phase = PH_IDLE;
		return 1'b1;
	endfunction

	// zero pulse count goes straight to the final check with SCL high
	function automatic bit enter_clocking(logic both_high);
		scl_en    = 1'b1;
		hold_cnt  = '0;
		pulse_cnt = '0;
		if (pulses_cfg == 5'd0) begin
			scl_lvl = 1'b1;
			return final_stop_or_end(both_high);
		end
		scl_lvl   = 1'b0;
		seq_phase = PH_CLK_LOW;
		return 1'b0;
	endfunction

	function automatic out_item_t predict_pins(in_item_t tick);
		logic      both_high;
		logic      done;
		out_item_t r;
		both_high = tick.scl_sample & tick.sda_sample;
		done = 1'b0;
		case (seq_phase)
			PH_IDLE: begin
				// start is only honored here
				if (tick.start_request) begin
					hold_cnt = '0;
					scl_en   = 1'b1;
					if (both_high) begin
						scl_lvl   = 1'b1;
						sda_en    = 1'b1;
						sda_lvl   = 1'b0;
						seq_phase = PH_A_LOW;
					end else begin
						scl_lvl   = 1'b0;
						seq_phase = PH_B_LOW;
					end
				end
			end
			PH_A_LOW: begin
				if (hold_over()) begin
					sda_lvl   = 1'b1;
					seq_phase = PH_A_HIGH;
				end
			end
			PH_C_LOW: begin
				if (hold_over()) begin
					sda_lvl   = 1'b1;
					seq_phase = PH_C_HIGH;
				end
			end
			PH_D_LOW: begin
				if (hold_over()) begin
					sda_lvl   = 1'b1;
					seq_phase = PH_D_HIGH;
				end
			end
			PH_A_HIGH, PH_C_HIGH: begin
				if (hold_over())
					done = enter_clocking(both_high);
			end
			PH_B_LOW: begin
				if (hold_over()) begin
					scl_lvl   = 1'b1;
					seq_phase = PH_B_HIGH;
				end
			end
			PH_B_HIGH: begin
				if (hold_over()) begin
					scl_en    = 1'b0;
					scl_lvl   = 1'b1;
					seq_phase = PH_B_SAMPLE;
				end
			end
			PH_B_SAMPLE: begin
				// SCL stays released through this second pseudo-stop
				hold_cnt = '0;
				if (both_high) begin
					sda_en    = 1'b1;
					sda_lvl   = 1'b0;
					seq_phase = PH_C_LOW;
				end else begin
					done = enter_clocking(both_high);
				end
			end
			PH_CLK_LOW: begin
				if (hold_over()) begin
					scl_lvl   = 1'b1;
					seq_phase = PH_CLK_HIGH;
				end
			end
			PH_CLK_HIGH: begin
				if (hold_over()) begin
					pulse_cnt = pulse_cnt + 5'd1;
					if (pulse_cnt >= pulses_cfg) begin
						done = final_stop_or_end(both_high);
					end else begin
						scl_lvl   = 1'b0;
						seq_phase = PH_CLK_LOW;
					end
				end
			end
			PH_D_HIGH: begin
				if (hold_over()) begin
					release_pins();
					seq_phase = PH_IDLE;
					done = 1'b1;
				end
			end
			default: begin
				release_pins();
				seq_phase = PH_IDLE;
				hold_cnt  = '0;
			end
		endcase
		r.scl_drive_enable = scl_en;
		r.scl_drive_level  = scl_lvl;
		r.sda_drive_enable = sda_en;
		r.sda_drive_level  = sda_lvl;
		r.busy_res         = (seq_phase != PH_IDLE);
		r.done_pulse       = done;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Result side: random backpressure, in-order compare of every beat.
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		out_ready <= no_stall || ($urandom_range(99) >= 26);
		if (arst_n && out_valid && out_ready) begin
			if (pins_expected.size() == 0) begin
				if (mismatches < 10)
					$display("out beat with nothing pending: %b", out_item);
				mismatches++;
			end else begin
				pins_want = pins_expected.pop_front();
				if (out_item !== pins_want) begin
					if (mismatches < 10)
						$display({"pin beat mismatch (exp/got): scl_en %b/%b scl_lvl %b/%b",
							" sda_en %b/%b sda_lvl %b/%b busy %b/%b done %b/%b"},
							pins_want.scl_drive_enable, out_item.scl_drive_enable,
							pins_want.scl_drive_level, out_item.scl_drive_level,
							pins_want.sda_drive_enable, out_item.sda_drive_enable,
							pins_want.sda_drive_level, out_item.sda_drive_level,
							pins_want.busy_res, out_item.busy_res,
							pins_want.done_pulse, out_item.done_pulse);
					mismatches++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus side.
	// ---------------------------------------------------------------

	// One tick beat. Random idle cycles first; valid then holds until taken.
	task automatic send_tick(input in_item_t tick);
		while (!no_stall && $urandom_range(99) < 26) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= tick;
		do @(posedge clk); while (!in_ready);
		pins_expected.push_back(predict_pins(tick));
		ticks_sent++;
	endtask

	// Stop feeding ticks and let every pending pin beat come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pins_expected.size() != 0) @(posedge clk);
	endtask

	// APB write: setup then access; upper data bits are junk on purpose.
	task automatic write_reg(input reg_idx_t idx, input logic [7:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {24'($urandom()), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_HALF_PERIOD: hold_cfg = value;
			REG_PULSE_COUNT: pulses_cfg = value[4:0];
			default: ;
		endcase
	endtask

	// Registers only change with the pipeline empty.
	task automatic retime(input logic [7:0] hold, input logic [4:0] pulses);
		wait_drained();
		write_reg(REG_HALF_PERIOD, hold);
		write_reg(REG_PULSE_COUNT, {3'b000, pulses});
	endtask

	// Start tick, then feed ticks until the mirror is idle again (or
	// max_ticks, if nonzero). Start is either held or sprinkled while busy.
	task automatic run_recovery(input line_mode_t mode, input bit hold_start,
			input int max_ticks);
		in_item_t tick;
		for (int n = 0; n < 20000; n++) begin
			if (n > 0 && seq_phase == PH_IDLE)
				break;
			if (max_ticks != 0 && n >= max_ticks)
				break;
			tick.start_request = (n == 0) || hold_start || ($urandom_range(7) == 0);
			case (mode)
				LINES_HIGH:    {tick.scl_sample, tick.sda_sample} = 2'b11;
				LINES_LOW:     {tick.scl_sample, tick.sda_sample} = 2'b00;
				LINES_RELEASE: {tick.scl_sample, tick.sda_sample} = (n == 0) ? 2'b00 : 2'b11;
				default: begin
					tick.scl_sample = ($urandom_range(9) < 7);
					tick.sda_sample = ($urandom_range(9) < 7);
				end
			endcase
			send_tick(tick);
		end
	endtask

	// reset values: 5-tick hold, 20 pulses, free bus -> both pseudo-stops
	task automatic test_reset_values();
		run_recovery(LINES_HIGH, 1'b0, 0);
	endtask

	// hold 0 acts as 1; pulse count 0 skips clocking
	task automatic test_zero_settings();
		retime(8'd0, 5'd0);
		run_recovery(LINES_HIGH, 1'b0, 0);
		run_recovery(LINES_LOW, 1'b0, 0);
		run_recovery(LINES_RELEASE, 1'b0, 0);
	endtask

	task automatic test_register_extremes();
		retime(8'd1, 5'd31);
		run_recovery(LINES_RANDOM, 1'b0, 0);
		// one full 255-tick level, then finish the run on a short hold
		retime(8'd255, 5'd1);
		run_recovery(LINES_LOW, 1'b0, 260);
		retime(8'd1, 5'd1);
		run_recovery(LINES_LOW, 1'b0, 0);
	endtask

	// stuck on start, free at the sample tick -> pseudo-stop with SCL released
	task automatic test_second_stop();
		retime(8'd2, 5'd3);
		run_recovery(LINES_RELEASE, 1'b0, 0);
	endtask

	// start held high throughout, done tick included, then an idle tick
	task automatic test_start_while_busy();
		retime(8'd1, 5'd2);
		run_recovery(LINES_RANDOM, 1'b1, 0);
		run_recovery(LINES_HIGH, 1'b1, 0);
		send_tick('{start_request: 1'b0, scl_sample: 1'b1, sda_sample: 1'b0});
	endtask

	// shrink the hold and pulse count partway through a sequence
	task automatic test_write_mid_sequence();
		retime(8'd6, 5'd4);
		run_recovery(LINES_HIGH, 1'b0, 4);
		retime(8'd2, 5'd1);
		run_recovery(LINES_RANDOM, 1'b0, 0);
	endtask

	// long stretch with neither side idling
	task automatic test_back_to_back();
		retime(8'd1, 5'd8);
		no_stall = 1'b1;
		run_recovery(LINES_RANDOM, 1'b0, 0);
		run_recovery(LINES_HIGH, 1'b0, 0);
		no_stall = 1'b0;
	endtask

	// Mostly full recoveries with random line behavior and settings, with
	// noise ticks between runs and some runs cut short by a tick limit.
	task automatic test_random_traffic();
		int target;
		target = ticks_sent + 150;
		while (ticks_sent < target) begin
			if ($urandom_range(3) == 0)
				retime(8'($urandom_range(0, 4)),
					($urandom_range(5) == 0) ? 5'($urandom_range(0, 31)) :
					5'($urandom_range(0, 5)));
			no_stall = ($urandom_range(9) == 0);
			repeat ($urandom_range(0, 2))
				send_tick(3'($urandom_range(7)));
			run_recovery(($urandom_range(4) == 0) ? line_mode_t'($urandom_range(0, 3)) :
				LINES_RANDOM, 1'($urandom_range(1)),
				($urandom_range(4) == 0) ? $urandom_range(1, 20) : 0);
		end
		no_stall = 1'b0;
	endtask

	initial begin
		// mirror at reset values
		hold_cfg   = HALF_PERIOD_RESET;
		pulses_cfg = PULSE_COUNT_RESET;
		seq_phase  = PH_IDLE;
		hold_cnt   = '0;
		pulse_cnt  = '0;
		release_pins();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_zero_settings();
		test_register_extremes();
		test_second_stop();
		test_start_while_busy();
		test_write_mid_sequence();
		test_back_to_back();
		test_random_traffic();

		// everything back, then wait for stray beats
		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+design
design/i2cbc_pkg.sv
design/i2cbc_regs.sv
design/i2cbc_step.sv
design/i2c_bus_clear_sequencer.sv
dv/i2c_bus_clear_sequencer_test.sv
